>>> rtl/core/mm3p_pkg.sv
// Shared types and constants for the streaming hash token block.
// Holds the mixing constants and the command record passed from the front end
// to the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mm3p_pkg;

   localparam logic [63:0] MIX_C1    = 64'h87c3_7b91_1142_53d5;
   localparam logic [63:0] MIX_C2    = 64'h4cf5_ad43_2745_937f;
   localparam logic [63:0] LANE_ADD1 = 64'h0000_0000_52dc_e729;
   localparam logic [63:0] LANE_ADD2 = 64'h0000_0000_3849_5ab5;
   localparam logic [63:0] FMIX_M1   = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] FMIX_M2   = 64'hc4ce_b9fe_1a85_ec53;
   localparam logic [63:0] TOKEN_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TOKEN_MAX = 64'h7fff_ffff_ffff_ffff;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic CMD_BLOCK  = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // One unit of work for the back end: either a full 16-byte block or the
   // finish of a key with its prepared tail words and total length.
   typedef struct packed {
      logic        kind;
      logic        has_lo;
      logic        has_hi;
      logic [63:0] word_lo;
      logic [63:0] word_hi;
      logic [63:0] length;
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/mm3p_fifo.sv
// Small first-in first-out queue of generic width and depth.
// Used between the front and back ends and for waiting results. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mm3p_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/mm3p_mul.sv
// Iterative 64 by 64 multiplier that keeps the low 64 bits of the product.
// One 32 by 32 partial product per cycle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mm3p_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             done,
   output logic [63:0]      result
);

   logic        busy_ff, busy_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mul_x;
   logic [31:0] mul_y;

   // The low product goes first; the two cross products land in the upper half.
   always_comb begin
      unique case (phase_ff)
         2'd0: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
         2'd1: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
         2'd2: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
         default: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
      endcase
   end

   assign prod_in = 64'(mul_x) * 64'(mul_y);
   assign done    = busy_ff && (phase_ff == 2'd3);
   assign result  = acc_ff + {prod_ff[31:0], 32'd0};

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         phase_in = 2'd0;
         a_in     = op_a;
         b_in     = op_b;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            busy_in = 1'b0;
         end
         if (phase_ff == 2'd1) begin
            acc_in = prod_ff;
         end else if (phase_ff == 2'd2) begin
            acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/mm3p_front.sv
// Front end: collects key bytes into blocks and prepares finish commands.
// Depends on mm3p_pkg for the command record and the operation codes.
`timescale 1ns / 1ps
`default_nettype none

module mm3p_front (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic        op,
   input  wire logic [7:0]  key_byte,
   output logic             cmd_push,
   output mm3p_pkg::cmd_type cmd
);

   logic [7:0]  bytes_ff [16];
   logic [3:0]  count_ff, count_in;
   logic [63:0] length_ff, length_in;
   logic [63:0] tail_lo;
   logic [63:0] tail_hi;
   logic [63:0] block_lo;
   logic [63:0] block_hi;

   function automatic logic [63:0] byte_sext(input logic [7:0] b);
      return {{56{b[7]}}, b};
   endfunction

   // Tail words: each live byte is sign-extended before it is shifted in.
   always_comb begin
      tail_lo = '0;
      tail_hi = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < count_ff) begin
            tail_lo = tail_lo ^ (byte_sext(bytes_ff[i]) << (8 * i));
         end
      end
      for (int i = 8; i < 16; i++) begin
         if (4'(i) < count_ff) begin
            tail_hi = tail_hi ^ (byte_sext(bytes_ff[i]) << (8 * (i - 8)));
         end
      end
   end

   // The sixteenth byte arrives on the port and goes straight into the block.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         block_lo[8*i +: 8] = bytes_ff[i];
      end
      for (int i = 0; i < 7; i++) begin
         block_hi[8*i +: 8] = bytes_ff[i+8];
      end
      block_hi[63:56] = key_byte;
   end

   always_comb begin
      count_in    = count_ff;
      length_in   = length_ff;
      cmd_push    = 1'b0;
      cmd.kind    = mm3p_pkg::CMD_BLOCK;
      cmd.has_lo  = 1'b0;
      cmd.has_hi  = 1'b0;
      cmd.word_lo = block_lo;
      cmd.word_hi = block_hi;
      cmd.length  = length_ff;
      if (accept) begin
         if (op == mm3p_pkg::OP_ABSORB) begin
            count_in  = count_ff + 4'd1;
            length_in = length_ff + 64'd1;
            cmd_push  = (count_ff == 4'd15);
         end else begin
            cmd_push    = 1'b1;
            cmd.kind    = mm3p_pkg::CMD_FINISH;
            cmd.has_lo  = (count_ff != 4'd0);
            cmd.has_hi  = (count_ff > 4'd8);
            cmd.word_lo = tail_lo;
            cmd.word_hi = tail_hi;
            count_in    = 4'd0;
            length_in   = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 4'd0;
         length_ff <= 64'd0;
      end else begin
         count_ff  <= count_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (op == mm3p_pkg::OP_ABSORB)) begin
         bytes_ff[count_ff] <= key_byte;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/mm3p_back.sv
// Back end: sequencer that mixes blocks and tails into the two lanes and
// finalizes the token. Depends on mm3p_pkg and instantiates mm3p_mul.
`timescale 1ns / 1ps
`default_nettype none

module mm3p_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mm3p_pkg::cmd_type cmd,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output logic [63:0]            rsp_token
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_B1M1 = 5'd1;
   localparam logic [4:0] ST_B1M2 = 5'd2;
   localparam logic [4:0] ST_B1F  = 5'd3;
   localparam logic [4:0] ST_B2M1 = 5'd4;
   localparam logic [4:0] ST_B2M2 = 5'd5;
   localparam logic [4:0] ST_B2F  = 5'd6;
   localparam logic [4:0] ST_T2M1 = 5'd7;
   localparam logic [4:0] ST_T2M2 = 5'd8;
   localparam logic [4:0] ST_T1M1 = 5'd9;
   localparam logic [4:0] ST_T1M2 = 5'd10;
   localparam logic [4:0] ST_F0   = 5'd11;
   localparam logic [4:0] ST_F1   = 5'd12;
   localparam logic [4:0] ST_F2   = 5'd13;
   localparam logic [4:0] ST_FM1  = 5'd14;
   localparam logic [4:0] ST_FM2  = 5'd15;
   localparam logic [4:0] ST_FM3  = 5'd16;
   localparam logic [4:0] ST_FM4  = 5'd17;
   localparam logic [4:0] ST_OUT  = 5'd18;

   logic [4:0]  state_ff, state_in;
   logic        issued_ff, issued_in;
   logic [63:0] h1_ff, h1_in;
   logic [63:0] h2_ff, h2_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] w0_ff, w0_in;
   logic [63:0] w1_ff, w1_in;
   logic [63:0] len_ff, len_in;
   logic        has_lo_ff, has_lo_in;
   logic        mul_state;
   logic        mul_start;
   logic [63:0] mul_a;
   logic [63:0] mul_b;
   logic        mul_done;
   logic [63:0] mul_result;
   logic [63:0] mul_fold;
   logic [63:0] lane_sum;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
      return (x << r) | (x >> (64 - r));
   endfunction

   mm3p_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_result)
   );

   assign mul_state = (state_ff == ST_B1M1) || (state_ff == ST_B1M2) ||
                      (state_ff == ST_B2M1) || (state_ff == ST_B2M2) ||
                      (state_ff == ST_T1M1) || (state_ff == ST_T1M2) ||
                      (state_ff == ST_T2M1) || (state_ff == ST_T2M2) ||
                      (state_ff == ST_FM1)  || (state_ff == ST_FM2)  ||
                      (state_ff == ST_FM3)  || (state_ff == ST_FM4);

   assign mul_start = mul_state && !issued_ff;
   assign mul_fold  = mul_result ^ (mul_result >> 33);
   assign lane_sum  = h1_ff + h2_ff;
   assign rsp_token = (lane_sum == mm3p_pkg::TOKEN_MIN) ? mm3p_pkg::TOKEN_MAX : lane_sum;

   always_comb begin
      unique case (state_ff)
         ST_B1M1, ST_T1M1: begin
            mul_a = w0_ff;
            mul_b = mm3p_pkg::MIX_C1;
         end
         ST_B2M1, ST_T2M1: begin
            mul_a = w1_ff;
            mul_b = mm3p_pkg::MIX_C2;
         end
         ST_B1M2, ST_T1M2: begin
            mul_a = k_ff;
            mul_b = mm3p_pkg::MIX_C2;
         end
         ST_B2M2, ST_T2M2: begin
            mul_a = k_ff;
            mul_b = mm3p_pkg::MIX_C1;
         end
         ST_FM1: begin
            mul_a = h1_ff;
            mul_b = mm3p_pkg::FMIX_M1;
         end
         ST_FM2: begin
            mul_a = h1_ff;
            mul_b = mm3p_pkg::FMIX_M2;
         end
         ST_FM3: begin
            mul_a = h2_ff;
            mul_b = mm3p_pkg::FMIX_M1;
         end
         ST_FM4: begin
            mul_a = h2_ff;
            mul_b = mm3p_pkg::FMIX_M2;
         end
         default: begin
            mul_a = k_ff;
            mul_b = mm3p_pkg::MIX_C1;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      h1_in     = h1_ff;
      h2_in     = h2_ff;
      k_in      = k_ff;
      w0_in     = w0_ff;
      w1_in     = w1_ff;
      len_in    = len_ff;
      has_lo_in = has_lo_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;

      if (mul_start) begin
         issued_in = 1'b1;
      end
      if (mul_done) begin
         issued_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               w0_in     = cmd.word_lo;
               w1_in     = cmd.word_hi;
               len_in    = cmd.length;
               has_lo_in = cmd.has_lo;
               if (cmd.kind == mm3p_pkg::CMD_BLOCK) begin
                  state_in = ST_B1M1;
               end else if (cmd.has_hi) begin
                  state_in = ST_T2M1;
               end else if (cmd.has_lo) begin
                  state_in = ST_T1M1;
               end else begin
                  state_in = ST_F0;
               end
            end
         end
         ST_B1M1: begin
            if (mul_done) begin
               k_in     = rotl(mul_result, 31);
               state_in = ST_B1M2;
            end
         end
         ST_B1M2: begin
            if (mul_done) begin
               h1_in    = rotl(h1_ff ^ mul_result, 27) + h2_ff;
               state_in = ST_B1F;
            end
         end
         ST_B1F: begin
            h1_in    = (h1_ff << 2) + h1_ff + mm3p_pkg::LANE_ADD1;
            state_in = ST_B2M1;
         end
         ST_B2M1: begin
            if (mul_done) begin
               k_in     = rotl(mul_result, 33);
               state_in = ST_B2M2;
            end
         end
         ST_B2M2: begin
            if (mul_done) begin
               h2_in    = rotl(h2_ff ^ mul_result, 31) + h1_ff;
               state_in = ST_B2F;
            end
         end
         ST_B2F: begin
            h2_in    = (h2_ff << 2) + h2_ff + mm3p_pkg::LANE_ADD2;
            state_in = ST_IDLE;
         end
         ST_T2M1: begin
            if (mul_done) begin
               k_in     = rotl(mul_result, 33);
               state_in = ST_T2M2;
            end
         end
         ST_T2M2: begin
            if (mul_done) begin
               h2_in    = h2_ff ^ mul_result;
               state_in = has_lo_ff ? ST_T1M1 : ST_F0;
            end
         end
         ST_T1M1: begin
            if (mul_done) begin
               k_in     = rotl(mul_result, 31);
               state_in = ST_T1M2;
            end
         end
         ST_T1M2: begin
            if (mul_done) begin
               h1_in    = h1_ff ^ mul_result;
               state_in = ST_F0;
            end
         end
         ST_F0: begin
            h1_in    = (h1_ff ^ len_ff) + (h2_ff ^ len_ff);
            state_in = ST_F1;
         end
         ST_F1: begin
            h2_in    = (h2_ff ^ len_ff) + h1_ff;
            h1_in    = h1_ff ^ (h1_ff >> 33);
            state_in = ST_F2;
         end
         ST_F2: begin
            h2_in    = h2_ff ^ (h2_ff >> 33);
            state_in = ST_FM1;
         end
         ST_FM1: begin
            if (mul_done) begin
               h1_in    = mul_fold;
               state_in = ST_FM2;
            end
         end
         ST_FM2: begin
            if (mul_done) begin
               h1_in    = mul_fold;
               state_in = ST_FM3;
            end
         end
         ST_FM3: begin
            if (mul_done) begin
               h2_in    = mul_fold;
               state_in = ST_FM4;
            end
         end
         ST_FM4: begin
            if (mul_done) begin
               h2_in    = mul_fold;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               h1_in    = 64'd0;
               h2_in    = 64'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
         h1_ff     <= 64'd0;
         h2_ff     <= 64'd0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         h1_ff     <= h1_in;
         h2_ff     <= h2_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      w0_ff     <= w0_in;
      w1_ff     <= w1_in;
      len_ff    <= len_in;
      has_lo_ff <= has_lo_in;
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && !cmd_empty)
      else $error("command taken outside the idle state");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full && (state_ff == ST_OUT))
      else $error("result pushed without room or outside the output state");

   a_lanes_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (state_ff == ST_IDLE) && (h1_ff == 64'd0) && (h2_ff == 64'd0))
      else $error("lanes not cleared after a token was delivered");

   a_done_was_issued: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> issued_ff && mul_state)
      else $error("multiplier finished without an issued product");

endmodule

`default_nettype wire

>>> rtl/core/murmur3_partition_token_core.sv
// Top level of the streaming hash token block.
// Depends on mm3p_pkg and instantiates mm3p_front, mm3p_fifo and mm3p_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                        Transaction moves
// -------   --------------------------   ---------------------------------
// request   req_push, req_full,          one key byte or a finish request
//           req_op, req_key_byte
// response  rsp_pop, rsp_empty,          one signed 64-bit token per key
//           rsp_token
//
// Every sixteenth byte and every finish become a command for the back end, which
// runs them one at a time on a shared iterative multiplier (one 32 by 32 partial
// product per cycle). The time a finish takes depends on the tail length.
// Reset is synchronous and active high; it clears both queues and all hash
// state. req_full rises while the command queue is full, and the back end
// holds a finished token when the response queue is full.
//
// The front end collects bytes and builds commands. The command queue lets it
// keep collecting the next block while the back end is still mixing.
module murmur3_partition_token_core #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_key_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic signed [63:0] rsp_token
);

   localparam int CMD_W = $bits(mm3p_pkg::cmd_type);

   logic              req_accept;
   logic              cmd_push;
   mm3p_pkg::cmd_type cmd_wr;
   mm3p_pkg::cmd_type cmd_rd;
   logic [CMD_W-1:0]  cmd_rd_bits;
   logic              cmd_full;
   logic              cmd_empty;
   logic              cmd_pop;
   logic              token_push;
   logic [63:0]       token_wr;
   logic              token_full;
   logic [63:0]       token_rd;

   // A request is taken whenever the command queue has room, so that the
   // transaction which completes a block or finishes a key always has a slot.
   assign req_full   = cmd_full;
   assign req_accept = req_push && !cmd_full;

   mm3p_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .op       (req_op),
      .key_byte (req_key_byte),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   mm3p_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_bits),
      .empty     (cmd_empty)
   );

   assign cmd_rd = mm3p_pkg::cmd_type'(cmd_rd_bits);

   mm3p_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (token_full),
      .rsp_push  (token_push),
      .rsp_token (token_wr)
   );

   // Finished tokens wait here so the back end can start on the next key.
   mm3p_fifo #(
      .WIDTH (64),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (token_push),
      .push_data (token_wr),
      .full      (token_full),
      .pop       (rsp_pop),
      .pop_data  (token_rd),
      .empty     (rsp_empty)
   );

   assign rsp_token = signed'(token_rd);

endmodule

`default_nettype wire
